### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared definitions for the text console engine
// Geometry, field widths, character codes, item modes and sequencer states.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CELL_W = $clog2(CELLS);

	// Port field widths
	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int POS_W  = 11;
	localparam int ATTR_W = 8;
	localparam int DATA_W = ATTR_W + CHAR_W;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam int                TAB_STOP   = 8;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
	localparam logic [DATA_W-1:0] RESET_BLANK = {ATTR_RESET, BLANK_CHAR};

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Cursor update produced for one put character
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             write_en;
		logic             scroll;
	} cursor_upd_t;

endpackage

### rtl/core/tcc_ram.sv
// ----------------------------------------------------------------------------
// tcc_ram: generic single-write, single-read RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/tcc_index.sv
// ----------------------------------------------------------------------------
// tcc_index: linear cell index unit
// Map a row and column to row*COLUMNS+col; shared by writes, reads and the
// reported cursor position.
// ----------------------------------------------------------------------------
module tcc_index (
	input  logic [tcc_pkg::ROW_W-1:0]  row,
	input  logic [tcc_pkg::COL_W-1:0]  col,
	output logic [tcc_pkg::CELL_W-1:0] idx
);
	import tcc_pkg::*;

	assign idx = CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);

endmodule

### rtl/core/tcc_cursor.sv
// ----------------------------------------------------------------------------
// tcc_cursor: cursor update for one put character
// Decode the control codes, advance and wrap the column, advance the row and
// flag a scroll when the row runs past the bottom.
// ----------------------------------------------------------------------------
module tcc_cursor (
	input  logic [tcc_pkg::COL_W-1:0]  col,
	input  logic [tcc_pkg::ROW_W-1:0]  row,
	input  logic [tcc_pkg::CHAR_W-1:0] char_code,
	output tcc_pkg::cursor_upd_t       upd
);
	import tcc_pkg::*;

	logic [COL_W:0] col_ext;
	logic [COL_W:0] col_nx;
	logic [ROW_W:0] row_nx;
	logic           row_inc;
	logic           wr;

	always_comb begin
		col_ext = {1'b0, col};
		col_nx  = col_ext;
		row_inc = 1'b0;
		wr      = 1'b0;
		unique case (char_code)
			CH_BS: begin
				if (col != '0) begin
					col_nx = col_ext - 1'b1;
				end
			end
			CH_TAB: begin
				col_nx = (col_ext + (COL_W+1)'(TAB_STOP)) & ~((COL_W+1)'(TAB_STOP - 1));
			end
			CH_CR: begin
				col_nx = '0;
			end
			CH_LF: begin
				col_nx  = '0;
				row_inc = 1'b1;
			end
			default: begin
				if (char_code >= BLANK_CHAR) begin
					wr     = 1'b1;
					col_nx = col_ext + 1'b1;
				end
			end
		endcase

		// wrap at the right edge
		if (col_nx >= (COL_W+1)'(COLUMNS)) begin
			col_nx  = '0;
			row_inc = 1'b1;
		end

		row_nx       = {1'b0, row} + (ROW_W+1)'(row_inc);
		upd.col      = col_nx[COL_W-1:0];
		upd.write_en = wr;
		upd.scroll   = (row_nx >= (ROW_W+1)'(ROWS));
		upd.row      = upd.scroll ? ROW_W'(ROWS - 1) : row_nx[ROW_W-1:0];
	end

endmodule

### rtl/core/text_console_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top: text-mode console engine
// Put, read and unused items pass through EXEC and FINISH; done is registered from
//   FINISH, and a new start is taken in the same cycle that done strobes.
// A scroll or clear adds one store walk over all CELLS (2000) cells, one cell per
//   cycle through the single RAM write port.
// Reset: cursor homes, attribute goes to 0x0F, then busy stays high while the
//   store is filled with blanks before the first item.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tcc_pkg::MODE_W-1:0]  mode,
	input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcc_pkg::RROW_W-1:0]  read_row,
	input  logic [tcc_pkg::RCOL_W-1:0]  read_col,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcc_pkg::ATTR_W-1:0]  cfg_data,
	output logic                        done,
	output logic [tcc_pkg::POS_W-1:0]   cursor_pos,
	output logic [tcc_pkg::DATA_W-1:0]  cell_data
);
	import tcc_pkg::*;

	// Sequencer
	state_t state_q, state_d;
	logic [CELL_W-1:0] scan_q;
	logic              scan_last;
	logic              copy_q;

	// Item held while it is worked on
	logic [MODE_W-1:0] mode_q;
	logic [CHAR_W-1:0] char_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic              rd_ok_q;

	// Cursor and attribute
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ATTR_W-1:0] attr_q;
	cursor_upd_t       upd;

	// Walk write-back stage: registered, in the cycle after the read of the walk
	logic              wb_valid_s1;
	logic [CELL_W-1:0] wb_addr_s1;
	logic              wb_copy_s1;
	logic [DATA_W-1:0] wb_fill_s1;

	// Result registers
	logic              done_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic [DATA_W-1:0] cell_data_q;

	// Shared index unit and RAM port signals
	logic              use_item;
	logic [ROW_W-1:0]  idx_row;
	logic [COL_W-1:0]  idx_col;
	logic [CELL_W-1:0] idx;
	logic [CELL_W-1:0] scan_src;
	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              walking;
	logic              accept;

	// The attribute register takes every beat on the config channel.
	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign walking   = (state_q == ST_INIT) || (state_q == ST_WALK);
	assign scan_last = (scan_q == CELL_W'(CELLS - 1));

	// The read item drives the index unit only while it executes; otherwise the
	// unit looks at the cursor (put write address, reported position).
	assign use_item = (state_q == ST_EXEC) && (mode_q == MODE_READ);
	assign idx_row  = use_item ? rrow_q : row_q;
	assign idx_col  = use_item ? rcol_q : col_q;

	tcc_index u_index (
		.row (idx_row),
		.col (idx_col),
		.idx (idx)
	);

	tcc_cursor u_cursor (
		.col       (col_q),
		.row       (row_q),
		.char_code (char_q),
		.upd       (upd)
	);

	// Scroll source cell: one row below the cell being written
	assign scan_src = CELL_W'({1'b0, scan_q} + (CELL_W+1)'(COLUMNS));

	// Write port: the walk write-back never meets an executing put, since a put
	// only executes after a pass through idle.
	always_comb begin
		ram_we    = wb_valid_s1 ||
			((state_q == ST_EXEC) && (mode_q == MODE_PUT) && upd.write_en);
		ram_waddr = wb_valid_s1 ? wb_addr_s1 : idx;
		if (wb_valid_s1) begin
			ram_wdata = wb_copy_s1 ? ram_rdata : wb_fill_s1;
		end else begin
			ram_wdata = {attr_q, char_q};
		end
		ram_raddr = walking ? scan_src : idx;
	end

	tcc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (((mode_q == MODE_PUT) && upd.scroll) || (mode_q == MODE_CLEAR)) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_WALK: begin
				if (scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: cursor, attribute, walk counter, strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= ATTR_RESET;
			scan_q      <= '0;
			copy_q      <= 1'b0;
			wb_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end

			// Advance the walk one cell per cycle; the write-back follows in the next cycle
			// so a copied cell has its read data back.
			wb_valid_s1 <= walking;
			if (walking) begin
				scan_q <= scan_last ? '0 : scan_q + 1'b1;
			end

			if (state_q == ST_EXEC) begin
				scan_q <= '0;
				if (mode_q == MODE_PUT) begin
					col_q  <= upd.col;
					row_q  <= upd.row;
					copy_q <= 1'b1;
				end else if (mode_q == MODE_CLEAR) begin
					col_q  <= '0;
					row_q  <= '0;
					copy_q <= 1'b0;
				end
			end

			done_q <= (state_q == ST_FINISH);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			char_q  <= char_code;
			rrow_q  <= ROW_W'(read_row);
			rcol_q  <= COL_W'(read_col);
			rd_ok_q <= (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
		end

		if (walking) begin
			wb_addr_s1 <= scan_q;
			// A scroll copies while a source row exists below and blanks the bottom row; other walks blank all.
			wb_copy_s1 <= copy_q && (state_q == ST_WALK) &&
				(32'(scan_q) < CELLS - COLUMNS);
			wb_fill_s1 <= (state_q == ST_INIT) ? RESET_BLANK : {attr_q, BLANK_CHAR};
		end

		// Read data of an executing read item lands in this cycle.
		if (state_q == ST_FINISH) begin
			cursor_pos_q <= POS_W'(idx);
			cell_data_q  <= ((mode_q == MODE_READ) && rd_ok_q) ? ram_rdata : '0;
		end
	end

	assign done       = done_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;

endmodule

### rtl/core/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker: port-level checks for the text console engine
// Watch the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [tcc_pkg::MODE_W-1:0] mode,
	input logic                       done,
	input logic [tcc_pkg::POS_W-1:0]  cursor_pos
);
	import tcc_pkg::*;

	// A result only shows once the engine is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted beat occupies the engine in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine free right after accepting a beat");

	// No result in the cycle after a beat is taken.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result too early after accept");

	// A clear walks the store, so the engine stays busy beyond its EXEC state.
	a_clear_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_CLEAR)) |=> busy ##1 busy)
		else $error("clear finished without a store walk");

	// The reported cursor always lies on the screen.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor_pos) < CELLS))
		else $error("cursor position off screen");

endmodule

bind text_console_cursor_scroll_top tcc_checker u_tcc_checker (.*);
